@@ src/vpts_pkg.sv @@
// Shared constants and types for the vertex projection engine.
package vpts_pkg;

  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_WORD_WIDTH = 32;

  localparam int ACTION_W      = 2;
  localparam int ENTRY_INDEX_W = 4;
  localparam int MAT_ENTRIES   = 16;
  localparam int VP_W          = 14;
  localparam int CFG_INDEX_W   = 1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CAP_LOG       = 60;
  localparam int PROD_W        = CAP_LOG + 2;

  localparam logic [ACTION_W-1:0] ACT_LOAD_MV   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_PJ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TRANSFORM = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED    = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_VIEWPORT_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VIEWPORT_HEIGHT = 1'b1;

  localparam logic [VP_W-1:0] VP_WIDTH_RESET  = 14'd640;
  localparam logic [VP_W-1:0] VP_HEIGHT_RESET = 14'd480;

  typedef struct packed {
    logic                     valid;
    logic [ACTION_W-1:0]      action;
    logic [ENTRY_INDEX_W-1:0] index;
  } q_ctl_t;

endpackage

@@ src/vpts_mulq.sv @@
// Fixed-point product with truncation toward zero and clip to the product cap.
module vpts_mulq import vpts_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic signed [WORD_WIDTH-1:0] a,
  input  logic signed [WORD_WIDTH-1:0] b,
  output logic signed [PROD_W-1:0]     p,
  output logic                         clip
);

  localparam int MW = (2 * WORD_WIDTH > PROD_W) ? 2 * WORD_WIDTH : PROD_W;
  localparam logic [MW-1:0] CAP = MW'(1) << CAP_LOG;

  logic signed [2*WORD_WIDTH-1:0] prod;
  logic signed [MW-1:0]           pe;
  logic [MW-1:0]                  mag;
  logic [MW-1:0]                  sh;
  logic [MW-1:0]                  res;
  logic [PROD_W-1:0]              resn;

  assign prod = a * b;
  assign pe   = MW'(prod);
  assign mag  = pe[MW-1] ? -pe : pe;
  assign sh   = mag >> FRAC_BITS;
  assign clip = sh > CAP;
  assign res  = clip ? CAP : sh;
  assign resn = res[PROD_W-1:0];
  assign p    = pe[MW-1] ? -resn : resn;

endmodule

@@ src/vpts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module vpts_div import vpts_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [WORD_WIDTH-1:0]       num,
  input  logic signed [WORD_WIDTH-1:0]       den,
  output logic [WORD_WIDTH+FRAC_BITS-1:0]    q_mag,
  output logic                               q_neg
);

  localparam int W  = WORD_WIDTH;
  localparam int QW = WORD_WIDTH + FRAC_BITS;

  logic [W-1:0]  rem   [QW];
  logic [QW-1:0] nb    [QW];
  logic [QW-1:0] qq    [QW];
  logic [W-1:0]  dd    [QW];
  logic          ng    [QW];

  logic [W-1:0]  rem_n [QW];
  logic [QW-1:0] nb_n  [QW];
  logic [QW-1:0] qq_n  [QW];
  logic [W-1:0]  dd_n  [QW];
  logic          ng_n  [QW];

  logic [W-1:0]  num_mag;
  logic [W-1:0]  den_mag;

  assign num_mag = num[W-1] ? W'(-num) : W'(num);
  assign den_mag = den[W-1] ? W'(-den) : W'(den);

  always_comb begin
    logic [W-1:0]  r_i;
    logic [QW-1:0] n_i;
    logic [QW-1:0] q_i;
    logic [W-1:0]  d_i;
    logic          s_i;
    logic [W:0]    r2;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        r_i = '0;
        n_i = {num_mag, {FRAC_BITS{1'b0}}};
        q_i = '0;
        d_i = den_mag;
        s_i = num[W-1] ^ den[W-1];
      end else begin
        r_i = rem[k-1];
        n_i = nb[k-1];
        q_i = qq[k-1];
        d_i = dd[k-1];
        s_i = ng[k-1];
      end
      r2       = {r_i, n_i[QW-1]};
      ge       = r2 >= {1'b0, d_i};
      rem_n[k] = ge ? W'(r2 - {1'b0, d_i}) : r2[W-1:0];
      nb_n[k]  = {n_i[QW-2:0], 1'b0};
      qq_n[k]  = {q_i[QW-2:0], ge};
      dd_n[k]  = d_i;
      ng_n[k]  = s_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= rem_n[k];
        nb[k]  <= nb_n[k];
        qq[k]  <= qq_n[k];
        dd[k]  <= dd_n[k];
        ng[k]  <= ng_n[k];
      end
    end
  end

  assign q_mag = qq[QW-1];
  assign q_neg = ng[QW-1];

endmodule

@@ src/vpts_front.sv @@
// Input acceptance, item classification and the short queue to the back end.
module vpts_front import vpts_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ACTION_W-1:0]          action,
  input  logic [ENTRY_INDEX_W-1:0]     entry_index,
  input  logic signed [WORD_WIDTH-1:0] entry_value,
  input  logic signed [WORD_WIDTH-1:0] coord_x,
  input  logic signed [WORD_WIDTH-1:0] coord_y,
  input  logic signed [WORD_WIDTH-1:0] coord_z,
  output q_ctl_t                       q_ctl,
  input  logic                         q_pop,
  output logic signed [WORD_WIDTH-1:0] q_a,
  output logic signed [WORD_WIDTH-1:0] q_b,
  output logic signed [WORD_WIDTH-1:0] q_c
);

  localparam int W     = WORD_WIDTH;
  localparam int DW    = ACTION_W + ENTRY_INDEX_W + 3 * W;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [DW-1:0]    mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             keep;
  logic             push;
  logic             pop;
  logic [W-1:0]     first_word;
  logic [DW-1:0]    rd_word;

  assign keep = (action == ACT_LOAD_MV) || (action == ACT_LOAD_PJ) ||
                (action == ACT_TRANSFORM);
  assign in_ready   = count != CNT_W'(QUEUE_DEPTH);
  assign push       = in_valid & in_ready & keep;
  assign pop        = q_pop & (count != '0);
  assign first_word = (action == ACT_TRANSFORM) ? coord_x : entry_value;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {action, entry_index, first_word, coord_y, coord_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_word      = mem[rd_ptr];
  assign q_ctl.valid  = count != '0;
  assign q_ctl.action = rd_word[DW-1 -: ACTION_W];
  assign q_ctl.index  = rd_word[3*W +: ENTRY_INDEX_W];
  assign q_a          = rd_word[2*W +: W];
  assign q_b          = rd_word[W +: W];
  assign q_c          = rd_word[0 +: W];

endmodule

@@ src/vpts_back.sv @@
// Transform pipeline: matrix products, perspective divide and viewport mapping.
module vpts_back import vpts_pkg::*; #(
  parameter int WORD_WIDTH = DEF_WORD_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  q_ctl_t                       q_ctl,
  input  logic signed [WORD_WIDTH-1:0] q_a,
  input  logic signed [WORD_WIDTH-1:0] q_b,
  input  logic signed [WORD_WIDTH-1:0] q_c,
  output logic                         q_pop,
  input  logic [VP_W-1:0]              vp_width,
  input  logic [VP_W-1:0]              vp_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] screen_x,
  output logic signed [WORD_WIDTH-1:0] screen_y,
  output logic signed [WORD_WIDTH-1:0] depth,
  output logic                         w_zero,
  output logic                         saturated
);

  localparam int W  = WORD_WIDTH;
  localparam int QW = WORD_WIDTH + FRAC_BITS;
  localparam int SW = (QW + 2 > 64) ? QW + 2 : 64;
  localparam int XW = (W + 18 > SW) ? W + 18 : SW;
  localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] WMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] ONE_X  = XW'(1) << FRAC_BITS;

  function automatic logic [W:0] sat_w(input logic signed [XW-1:0] v);
    logic [W:0] r;
    if (v > WMAX_X) begin
      r = {1'b1, WMAX_X[W-1:0]};
    end else if (v < WMIN_X) begin
      r = {1'b1, WMIN_X[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic signed [XW-1:0] half_tz(input logic signed [XW-1:0] v);
    logic [XW-1:0] t;
    t = v + XW'(v[XW-1]);
    return $signed(t) >>> 1;
  endfunction

  logic en;
  assign en    = !out_valid || out_ready;
  assign q_pop = en;

  logic signed [W-1:0] mv [MAT_ENTRIES];
  logic signed [W-1:0] pj [MAT_ENTRIES];
  logic signed [W-1:0] vin [3];

  assign vin[0] = q_a;
  assign vin[1] = q_b;
  assign vin[2] = q_c;

  // model-view products
  logic signed [PROD_W-1:0] m_prod [12];
  logic                     m_clip [12];

  for (genvar j = 0; j < 12; j++) begin : g_mv_lane
    vpts_mulq #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mulq (
      .a    (mv[j]),
      .b    (vin[j/4]),
      .p    (m_prod[j]),
      .clip (m_clip[j])
    );
  end

  logic                     s1_valid;
  logic [ACTION_W-1:0]      s1_act;
  logic [ENTRY_INDEX_W-1:0] s1_idx;
  logic signed [W-1:0]      s1_val;
  logic signed [PROD_W-1:0] s1_prod [12];
  logic signed [W-1:0]      s1_trans [4];
  logic                     s1_flag;
  logic                     m_any_clip;

  always_comb begin
    m_any_clip = 1'b0;
    for (int j = 0; j < 12; j++) begin
      m_any_clip = m_any_clip | m_clip[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en && q_ctl.valid && q_ctl.action == ACT_LOAD_MV) begin
      mv[q_ctl.index] <= q_a;
    end
    if (en && s1_valid && s1_act == ACT_LOAD_PJ) begin
      pj[s1_idx] <= s1_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_act  <= q_ctl.action;
      s1_idx  <= q_ctl.index;
      s1_val  <= q_a;
      s1_flag <= m_any_clip;
      for (int j = 0; j < 12; j++) begin
        s1_prod[j] <= m_prod[j];
      end
      for (int i = 0; i < 4; i++) begin
        s1_trans[i] <= mv[12+i];
      end
    end
  end

  // model-view sums
  logic [W:0] f_sat [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f_sat[i] = sat_w(XW'(s1_prod[i]) + XW'(s1_prod[4+i]) + XW'(s1_prod[8+i]) +
                       XW'(s1_trans[i]));
    end
  end

  logic                s2_xf;
  logic signed [W-1:0] s2_f [4];
  logic                s2_flag;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_flag <= s1_flag | f_sat[0][W] | f_sat[1][W] | f_sat[2][W] | f_sat[3][W];
      for (int i = 0; i < 4; i++) begin
        s2_f[i] <= f_sat[i][W-1:0];
      end
    end
  end

  // projection products
  logic signed [PROD_W-1:0] p_prod [12];
  logic                     p_clip [12];

  for (genvar c = 0; c < 4; c++) begin : g_pj_col
    for (genvar i = 0; i < 3; i++) begin : g_pj_row
      vpts_mulq #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mulq (
        .a    (pj[c*4+i]),
        .b    (s2_f[c]),
        .p    (p_prod[c*3+i]),
        .clip (p_clip[c*3+i])
      );
    end
  end

  logic [W:0] w_sat;
  logic       p_any_clip;

  always_comb begin
    p_any_clip = 1'b0;
    for (int j = 0; j < 12; j++) begin
      p_any_clip = p_any_clip | p_clip[j];
    end
  end

  assign w_sat = sat_w(-XW'(s2_f[2]));

  logic                     s3_xf;
  logic signed [PROD_W-1:0] s3_prod [12];
  logic signed [W-1:0]      s3_w;
  logic                     s3_flag;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_w    <= w_sat[W-1:0];
      s3_flag <= s2_flag | p_any_clip | w_sat[W];
      for (int j = 0; j < 12; j++) begin
        s3_prod[j] <= p_prod[j];
      end
    end
  end

  // projection sums
  logic [W:0] g_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_sat[i] = sat_w(XW'(s3_prod[i]) + XW'(s3_prod[3+i]) + XW'(s3_prod[6+i]) +
                       XW'(s3_prod[9+i]));
    end
  end

  logic                s4_xf;
  logic signed [W-1:0] s4_g [3];
  logic signed [W-1:0] s4_w;
  logic                s4_wz;
  logic                s4_flag;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_w    <= s3_w;
      s4_wz   <= s3_w == '0;
      s4_flag <= s3_flag | g_sat[0][W] | g_sat[1][W] | g_sat[2][W];
      for (int i = 0; i < 3; i++) begin
        s4_g[i] <= g_sat[i][W-1:0];
      end
    end
  end

  // perspective divide
  logic [QW-1:0] d_mag [3];
  logic          d_neg [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vpts_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .en    (en),
      .num   (s4_g[i]),
      .den   (s4_w),
      .q_mag (d_mag[i]),
      .q_neg (d_neg[i])
    );
  end

  logic dv_xf   [QW];
  logic dv_wz   [QW];
  logic dv_flag [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_wz[0]   <= s4_wz;
      dv_flag[0] <= s4_flag;
      for (int k = 1; k < QW; k++) begin
        dv_wz[k]   <= dv_wz[k-1];
        dv_flag[k] <= dv_flag[k-1];
      end
    end
  end

  logic [W:0] n_sat [3];

  always_comb begin
    logic signed [XW-1:0] qx;
    for (int i = 0; i < 3; i++) begin
      qx       = XW'(d_mag[i]);
      n_sat[i] = sat_w(d_neg[i] ? -qx : qx);
    end
  end

  logic                s5_xf;
  logic signed [W-1:0] s5_n [3];
  logic                s5_wz;
  logic                s5_flag;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_wz   <= dv_wz[QW-1];
      s5_flag <= dv_flag[QW-1] | n_sat[0][W] | n_sat[1][W] | n_sat[2][W];
      for (int i = 0; i < 3; i++) begin
        s5_n[i] <= n_sat[i][W-1:0];
      end
    end
  end

  // viewport mapping
  logic signed [XW-1:0] ax;
  logic signed [XW-1:0] ay;
  logic signed [W+16:0] px;
  logic signed [W+16:0] py;
  logic signed [XW-1:0] hv1;
  logic [W:0]           sx_sat;
  logic [W:0]           sy_sat;
  logic [W:0]           dz_sat;

  assign ax     = XW'(s5_n[0]) + ONE_X;
  assign ay     = XW'(s5_n[1]) + ONE_X;
  assign px     = $signed(ax[W+16:0]) * $signed({1'b0, vp_width});
  assign py     = $signed(ay[W+16:0]) * $signed({1'b0, vp_height});
  assign hv1    = $signed(XW'(vp_height)) <<< FRAC_BITS;
  assign sx_sat = sat_w(half_tz(XW'(px)));
  assign sy_sat = sat_w(hv1 - half_tz(XW'(py)));
  assign dz_sat = sat_w(half_tz(ONE_X + XW'(s5_n[2])));

  always_ff @(posedge clk) begin
    if (en) begin
      if (s5_wz) begin
        screen_x  <= '0;
        screen_y  <= '0;
        depth     <= '0;
        w_zero    <= 1'b1;
        saturated <= 1'b0;
      end else begin
        screen_x  <= sx_sat[W-1:0];
        screen_y  <= sy_sat[W-1:0];
        depth     <= dz_sat[W-1:0];
        w_zero    <= 1'b0;
        saturated <= s5_flag | sx_sat[W] | sy_sat[W] | dz_sat[W];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_xf     <= 1'b0;
      s3_xf     <= 1'b0;
      s4_xf     <= 1'b0;
      s5_xf     <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < QW; k++) begin
        dv_xf[k] <= 1'b0;
      end
    end else if (en) begin
      s1_valid  <= q_ctl.valid;
      s2_xf     <= s1_valid && s1_act == ACT_TRANSFORM;
      s3_xf     <= s2_xf;
      s4_xf     <= s3_xf;
      dv_xf[0]  <= s4_xf;
      for (int k = 1; k < QW; k++) begin
        dv_xf[k] <= dv_xf[k-1];
      end
      s5_xf     <= dv_xf[QW-1];
      out_valid <= s5_xf;
    end
  end

  a_wzero_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_zero |-> !saturated && screen_x == '0 && screen_y == '0 && depth == '0)
    else $error("zero divisor result carries data");

  a_rise_enabled: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(en) && $past(s5_xf))
    else $error("result appeared without a transform leaving the pipeline");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s5_xf) && $stable(s4_xf) && $stable(s1_valid))
    else $error("pipeline advanced during an output stall");

endmodule

@@ src/vertex_project_to_screen_core.sv @@
// Top level of the vertex projection engine: configuration registers and front/back wiring.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, action, entry_index,   | input
//          | entry_value, coord_x, coord_y, coord_z    |
//  out     | out_valid/out_ready, screen_x, screen_y,  | output
//          | depth, w_zero, saturated                  |
//  cfg     | cfg_we, cfg_index, cfg_data               | input
//
// One item per cycle is accepted and completed while the output is not stalled and the
// queue is not full; a transform result passes through the queue, stages s1 to s4, the
// one-bit-per-stage divider, s5 and the output register.
// Synchronous reset clears the queue and all valid bits; viewport returns to 640x480.
// A stalled output freezes the back pipeline; the four-entry queue keeps accepting
// until it is full.
module vertex_project_to_screen_core import vpts_pkg::*; #(
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int WORD_WIDTH = DEF_WORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ACTION_W-1:0]          action,
  input  logic [ENTRY_INDEX_W-1:0]     entry_index,
  input  logic signed [WORD_WIDTH-1:0] entry_value,
  input  logic signed [WORD_WIDTH-1:0] coord_x,
  input  logic signed [WORD_WIDTH-1:0] coord_y,
  input  logic signed [WORD_WIDTH-1:0] coord_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] screen_x,
  output logic signed [WORD_WIDTH-1:0] screen_y,
  output logic signed [WORD_WIDTH-1:0] depth,
  output logic                         w_zero,
  output logic                         saturated,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [VP_W-1:0]              cfg_data
);

  logic [VP_W-1:0]              vp_width;
  logic [VP_W-1:0]              vp_height;
  q_ctl_t                       q_ctl;
  logic                         q_pop;
  logic signed [WORD_WIDTH-1:0] q_a;
  logic signed [WORD_WIDTH-1:0] q_b;
  logic signed [WORD_WIDTH-1:0] q_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp_width  <= VP_WIDTH_RESET;
      vp_height <= VP_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIEWPORT_WIDTH:  vp_width  <= cfg_data;
        CFG_VIEWPORT_HEIGHT: vp_height <= cfg_data;
        default: ;
      endcase
    end
  end

  vpts_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .q_ctl       (q_ctl),
    .q_pop       (q_pop),
    .q_a         (q_a),
    .q_b         (q_b),
    .q_c         (q_c)
  );

  vpts_back #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_ctl     (q_ctl),
    .q_a       (q_a),
    .q_b       (q_b),
    .q_c       (q_c),
    .q_pop     (q_pop),
    .vp_width  (vp_width),
    .vp_height (vp_height),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .depth     (depth),
    .w_zero    (w_zero),
    .saturated (saturated)
  );

endmodule
